[rtl/apt_pkg.sv]
`timescale 1ns / 1ps

package apt_pkg;

  localparam int REG_W = 48;

  localparam logic [REG_W-1:0] X_AXIS_RST = 48'h0000_0000_0100;
  localparam logic [REG_W-1:0] Y_AXIS_RST = 48'h0000_0100_0000;
  localparam logic [REG_W-1:0] Z_AXIS_RST = 48'h0100_0000_0000;
  localparam logic [REG_W-1:0] W_AXIS_RST = 48'h0000_0000_0000;

  typedef enum logic [1:0] {
    REG_X_AXIS = 2'd0,
    REG_Y_AXIS = 2'd1,
    REG_Z_AXIS = 2'd2,
    REG_W_AXIS = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_VEC     = 2'd0,
    MODE_PNT     = 2'd1,
    MODE_INV_VEC = 2'd2,
    MODE_INV_PNT = 2'd3
  } mode_t;

endpackage

[rtl/affine_point_transform_unit.sv]
// pipeline: one register stage each for operand prep, the nine multipliers, the row adders and
// the shift/saturate, which drives out_valid
// throughput: one item per cycle while the output is not stalled; a stall on the output holds
// each full stage with no empty stage after it, and empty stages still fill, so bubbles are squeezed out
// reset: synchronous active-low rst_n empties the pipeline and loads the identity matrix
// with zero translation
`timescale 1ns / 1ps

module affine_point_transform_unit
  import apt_pkg::*;
#(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_idx,
  input  logic [REG_W-1:0]             cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_mode,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic signed [COORD_BITS-1:0] in_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] out_res_x,
  output logic signed [COORD_BITS-1:0] out_res_y,
  output logic signed [COORD_BITS-1:0] out_res_z,
  output logic                         out_clipped
);

  localparam int CB     = COORD_BITS;
  localparam int PAD_W  = REG_W + 3 * CB;
  localparam int PROD_W = 2 * CB + 4;
  localparam int TR_W   = CB + FRAC_BITS + 3;
  localparam int RAW_W  = (PROD_W > TR_W) ? PROD_W : TR_W;
  localparam int ACC_W  = (RAW_W > 64) ? 64 : RAW_W;

  localparam logic signed [CB-1:0] RES_MAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] RES_MIN = {1'b1, {(CB-1){1'b0}}};

  // matrix registers
  logic [REG_W-1:0] x_axis_row_r;
  logic [REG_W-1:0] y_axis_row_r;
  logic [REG_W-1:0] z_axis_row_r;
  logic [REG_W-1:0] w_axis_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_axis_row_r <= X_AXIS_RST;
      y_axis_row_r <= Y_AXIS_RST;
      z_axis_row_r <= Z_AXIS_RST;
      w_axis_row_r <= W_AXIS_RST;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_X_AXIS: x_axis_row_r <= cfg_wdata;
        REG_Y_AXIS: y_axis_row_r <= cfg_wdata;
        REG_Z_AXIS: z_axis_row_r <= cfg_wdata;
        REG_W_AXIS: w_axis_row_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // lane unpacking, lanes past the register read as zero
  logic [PAD_W-1:0]         pad_x, pad_y, pad_z, pad_w;
  logic signed [CB-1:0]     mat [3][3];
  logic signed [CB-1:0]     trans [3];

  always_comb begin
    pad_x = PAD_W'(x_axis_row_r);
    pad_y = PAD_W'(y_axis_row_r);
    pad_z = PAD_W'(z_axis_row_r);
    pad_w = PAD_W'(w_axis_row_r);
    for (int k = 0; k < 3; k++) begin
      mat[0][k] = pad_x[k*CB +: CB];
      mat[1][k] = pad_y[k*CB +: CB];
      mat[2][k] = pad_z[k*CB +: CB];
      trans[k]  = pad_w[k*CB +: CB];
    end
  end

  // stage handshake
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic s1_ready, s2_ready, s3_ready, s4_ready;

  assign s4_ready = !out_valid_r || !out_stall;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;

  // stage 1: operand prep, inverse point subtracts the translation
  mode_t                s1_mode_r;
  logic signed [CB:0]   s1_v_r [3];
  logic signed [CB:0]   s1_v_nxt [3];
  logic signed [CB-1:0] in_vec [3];

  always_comb begin
    in_vec[0] = in_x;
    in_vec[1] = in_y;
    in_vec[2] = in_z;
    for (int k = 0; k < 3; k++) begin
      if (mode_t'(in_mode) == MODE_INV_PNT) begin
        s1_v_nxt[k] = (CB+1)'(in_vec[k]) - (CB+1)'(trans[k]);
      end else begin
        s1_v_nxt[k] = (CB+1)'(in_vec[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_mode_r <= mode_t'(in_mode);
      s1_v_r    <= s1_v_nxt;
    end
  end

  // stage 2: nine products
  mode_t                   s2_mode_r;
  logic signed [ACC_W-1:0] s2_prod_r [3][3];
  logic signed [ACC_W-1:0] s2_prod_nxt [3][3];
  logic signed [CB-1:0]    coef [3][3];
  logic                    s1_inv;

  assign s1_inv = (s1_mode_r == MODE_INV_VEC) || (s1_mode_r == MODE_INV_PNT);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef[i][j]        = s1_inv ? mat[i][j] : mat[j][i];
        s2_prod_nxt[i][j] = ACC_W'(s1_v_r[j]) * ACC_W'(coef[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      s2_mode_r <= s1_mode_r;
      s2_prod_r <= s2_prod_nxt;
    end
  end

  // stage 3: row sums plus translation for forward points (MODE_PNT)
  logic signed [ACC_W-1:0] s3_acc_r [3];
  logic signed [ACC_W-1:0] s3_acc_nxt [3];
  logic signed [ACC_W-1:0] trans_term [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      trans_term[i] = (s2_mode_r == MODE_PNT) ? (ACC_W'(trans[i]) <<< FRAC_BITS) : '0;
      s3_acc_nxt[i] = s2_prod_r[i][0] + s2_prod_r[i][1] + s2_prod_r[i][2] + trans_term[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid_r) begin
      s3_acc_r <= s3_acc_nxt;
    end
  end

  // stage 4: shift, saturate, output register
  logic signed [ACC_W-1:0] shifted [3];
  logic signed [CB-1:0]    res_nxt [3];
  logic [2:0]              clip_nxt;
  logic signed [CB-1:0]    res_r [3];
  logic                    clipped_r;
  logic [ACC_W-CB:0]       upper [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shifted[i] = s3_acc_r[i] >>> FRAC_BITS;
      upper[i]   = shifted[i][ACC_W-1:CB-1];
      if (!shifted[i][ACC_W-1] && (|upper[i])) begin
        res_nxt[i]  = RES_MAX;
        clip_nxt[i] = 1'b1;
      end else if (shifted[i][ACC_W-1] && !(&upper[i])) begin
        res_nxt[i]  = RES_MIN;
        clip_nxt[i] = 1'b1;
      end else begin
        res_nxt[i]  = shifted[i][CB-1:0];
        clip_nxt[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s4_ready) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid_r) begin
      res_r     <= res_nxt;
      clipped_r <= |clip_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_res_x   = res_r[0];
  assign out_res_y   = res_r[1];
  assign out_res_z   = res_r[2];
  assign out_clipped = clipped_r;

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r && !s1_valid_r)
    else $error("pipeline not empty after reset");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s1_valid_r)
    else $error("accepted item missing from stage 1");

  a_stall_holds_sum: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r && out_valid_r && out_stall |=> s3_valid_r && $stable(s3_acc_r[0]))
    else $error("row sum lost during stall");

  a_clip_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_clipped |->
      (out_res_x == RES_MAX) || (out_res_x == RES_MIN) ||
      (out_res_y == RES_MAX) || (out_res_y == RES_MIN) ||
      (out_res_z == RES_MAX) || (out_res_z == RES_MIN))
    else $error("clipped set with no component at a bound");
`endif

endmodule

[tb/affine_point_transform_unit_tb.sv]
`timescale 1ns / 1ps

module affine_point_transform_unit_tb
  import apt_pkg::*;
();

  localparam int CB = 16;
  localparam int FB = 8;
  localparam longint COORD_MAX = 2 ** (CB - 1) - 1;
  localparam longint COORD_MIN = -(2 ** (CB - 1));
  localparam int MAX_WAIT = 18;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 200;

  typedef struct {
    mode_t mode;
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
  } vertex_in_t;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic clipped;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = REG_X_AXIS;
  logic [REG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = MODE_VEC;
  logic signed [CB-1:0] in_x = '0;
  logic signed [CB-1:0] in_y = '0;
  logic signed [CB-1:0] in_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CB-1:0] out_res_x;
  logic signed [CB-1:0] out_res_y;
  logic signed [CB-1:0] out_res_z;
  logic out_clipped;

  logic [REG_W-1:0] axis_rows [4] = '{X_AXIS_RST, Y_AXIS_RST, Z_AXIS_RST, W_AXIS_RST};
  vertex_in_t pending_items [$];
  vertex_t expected_vertices [$];
  int mismatch_count = 0;
  int in_gap = 0;
  int in_stretch = 0;
  bit in_quiet = 1'b0;
  int out_hold = 0;
  int out_stretch = 0;
  bit out_quiet = 1'b0;

  affine_point_transform_unit #(
    .COORD_BITS(CB),
    .FRAC_BITS (FB)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_x       (in_x),
    .in_y       (in_y),
    .in_z       (in_z),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res_x  (out_res_x),
    .out_res_y  (out_res_y),
    .out_res_z  (out_res_z),
    .out_clipped(out_clipped)
  );

  always #1 clk = ~clk;

  function automatic vertex_t transform_vertex(mode_t mode, logic signed [CB-1:0] x,
                                               logic signed [CB-1:0] y,
                                               logic signed [CB-1:0] z);
    longint vec [3];
    longint mat [3][3];
    longint tr [3];
    longint acc;
    longint scaled;
    logic signed [CB-1:0] lanes [3];
    vertex_t res;
    res.clipped = 1'b0;
    vec[0] = x;
    vec[1] = y;
    vec[2] = z;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        mat[r][k] = longint'($signed(axis_rows[r][CB*k +: CB]));
      end
    end
    for (int k = 0; k < 3; k++) begin
      tr[k] = longint'($signed(axis_rows[REG_W_AXIS][CB*k +: CB]));
    end
    if (mode == MODE_INV_PNT) begin
      for (int i = 0; i < 3; i++) vec[i] = vec[i] - tr[i];
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) begin
        if (mode == MODE_VEC || mode == MODE_PNT) acc += vec[j] * mat[j][i];
        else acc += vec[j] * mat[i][j];
      end
      if (mode == MODE_PNT) acc += tr[i] <<< FB;
      scaled = acc >>> FB;
      if (scaled > COORD_MAX) begin
        scaled = COORD_MAX;
        res.clipped = 1'b1;
      end else if (scaled < COORD_MIN) begin
        scaled = COORD_MIN;
        res.clipped = 1'b1;
      end
      lanes[i] = scaled[CB-1:0];
    end
    res.x = lanes[0];
    res.y = lanes[1];
    res.z = lanes[2];
    return res;
  endfunction

  // stretches with no waits and stretches of random waits, each stretch's kind drawn at random
  function automatic int draw_wait(ref int stretch, ref bit quiet);
    if (stretch == 0) begin
      stretch = $urandom_range(8, 64);
      quiet = ($urandom_range(0, 2) == 0);
    end
    stretch--;
    return quiet ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  function automatic logic signed [CB-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3, 4, 5: return CB'($urandom_range(0, 4095) - 2048);
      default: return CB'($urandom);
    endcase
  endfunction

  function automatic logic [CB-1:0] pick_lane();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'h0100;
      4: return 16'hFF00;
      5, 6, 7: return CB'($urandom_range(0, 1023) - 512);
      default: return CB'($urandom);
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_row();
    return {pick_lane(), pick_lane(), pick_lane()};
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic write_row(reg_idx_t idx, logic [REG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    axis_rows[idx] = value;
  endtask

  task automatic load_matrix(logic [REG_W-1:0] xr, logic [REG_W-1:0] yr,
                             logic [REG_W-1:0] zr, logic [REG_W-1:0] wr);
    write_row(REG_X_AXIS, xr);
    write_row(REG_Y_AXIS, yr);
    write_row(REG_Z_AXIS, zr);
    write_row(REG_W_AXIS, wr);
  endtask

  task automatic queue_vertex(mode_t mode, logic signed [CB-1:0] x,
                              logic signed [CB-1:0] y, logic signed [CB-1:0] z);
    vertex_in_t item;
    item.mode = mode;
    item.x = x;
    item.y = y;
    item.z = z;
    pending_items.push_back(item);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_valid || expected_vertices.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin : driver
    vertex_in_t item;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_vertices.push_back(transform_vertex(mode_t'(in_mode), in_x, in_y, in_z));
      end
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          item = pending_items.pop_front();
          in_valid <= 1'b1;
          in_mode <= item.mode;
          in_x <= item.x;
          in_y <= item.y;
          in_z <= item.z;
          in_gap <= draw_wait(in_stretch, in_quiet);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    vertex_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_vertices.size() == 0) begin
          report_mismatch($sformatf("unexpected item x=%0d y=%0d z=%0d",
                                    out_res_x, out_res_y, out_res_z));
        end else begin
          want = expected_vertices.pop_front();
          if (out_res_x !== want.x)
            report_mismatch($sformatf("res_x got %0d expected %0d", out_res_x, want.x));
          if (out_res_y !== want.y)
            report_mismatch($sformatf("res_y got %0d expected %0d", out_res_y, want.y));
          if (out_res_z !== want.z)
            report_mismatch($sformatf("res_z got %0d expected %0d", out_res_z, want.z));
          if (out_clipped !== want.clipped)
            report_mismatch($sformatf("clipped got %0b expected %0b",
                                      out_clipped, want.clipped));
        end
        out_hold = draw_wait(out_stretch, out_quiet);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_stall <= (out_hold != 0);
    end
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity matrix after reset
    for (int m = 0; m < 4; m++) begin
      queue_vertex(mode_t'(m), 16'sh0000, 16'sh0000, 16'sh0000);
      queue_vertex(mode_t'(m), 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      queue_vertex(mode_t'(m), 16'sh8000, 16'sh8000, 16'sh8000);
    end
    drain();

    // extreme rows: saturation, negative rounding, wide difference in inverse point
    load_matrix(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h0080_0080_0080,
                48'h8000_8000_8000);
    for (int m = 0; m < 4; m++) begin
      queue_vertex(mode_t'(m), 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      queue_vertex(mode_t'(m), 16'sh8000, 16'sh8000, 16'sh8000);
      queue_vertex(mode_t'(m), -16'sd1, 16'sh0000, 16'sh0000);
    end
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0)
        load_matrix(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                    48'hFFFF_FFFF_FFFF);
      else if (p == 1)
        load_matrix('0, '0, '0, '0);
      else
        load_matrix(pick_row(), pick_row(), pick_row(), pick_row());
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        queue_vertex(mode_t'($urandom_range(0, 3)), pick_coord(), pick_coord(),
                     pick_coord());
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
